// ----- hw/rtl/sap_pkg.sv -----
// Shared types and constants for the supervisor automata player.
// Holds the classified command record passed from the front end to the sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sap_pkg;

	localparam int NUM_EVENTS_DEF      = 32;
	localparam int NUM_SUPERVISORS_DEF = 8;
	localparam int TABLE_DEPTH_DEF     = 4096;
	localparam int STATE_BITS_DEF      = 16;

	localparam int ADDRESS_W = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE       = 2'd1;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_MEMB  = 3'd1;
	localparam logic [2:0] MODE_LOAD  = 3'd2;
	localparam logic [2:0] MODE_RESET = 3'd3;
	localparam logic [2:0] MODE_EVENT = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_MEMB,
		OP_LOAD,
		OP_RESET,
		OP_EVENT
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [ADDRESS_W-1:0] address;
		logic [7:0]           byte_value;
		logic [2:0]           supervisor;
		logic [31:0]          event_mask;
		logic [15:0]          state_value;
		logic [4:0]           event_req;
	} cmd_t;

endpackage

// ----- hw/rtl/sap_front.sv -----
// Front end: accepts input items, classifies them and queues them for the sequencer.
// Depends on sap_pkg.
`timescale 1ns / 1ps

module sap_front #(
	parameter int NUM_EVENTS_P      = sap_pkg::NUM_EVENTS_DEF,
	parameter int NUM_SUPERVISORS_P = sap_pkg::NUM_SUPERVISORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [2:0]                      mode,
	input  logic [sap_pkg::ADDRESS_W-1:0]   address,
	input  logic [7:0]                      byte_value,
	input  logic [2:0]                      supervisor,
	input  logic [31:0]                     event_mask,
	input  logic [15:0]                     state_value,
	input  logic [4:0]                      event_req,
	output logic                            cmd_valid,
	input  logic                            cmd_pop,
	output sap_pkg::cmd_t                   cmd
);
	import sap_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       sup_ok;
	logic       ev_ok;
	logic       do_push;
	logic       do_pop;

	assign sup_ok = int'(supervisor) < NUM_SUPERVISORS_P;
	assign ev_ok  = int'(event_req) < NUM_EVENTS_P;

	always_comb begin
		cls.address     = address;
		cls.byte_value  = byte_value;
		cls.supervisor  = supervisor;
		cls.event_mask  = event_mask;
		cls.state_value = state_value;
		cls.event_req   = event_req;
		unique case (mode)
			MODE_WRITE: cls.op = OP_WRITE;
			MODE_MEMB:  cls.op = sup_ok ? OP_MEMB : OP_NONE;
			MODE_LOAD:  cls.op = sup_ok ? OP_LOAD : OP_NONE;
			MODE_RESET: cls.op = OP_RESET;
			MODE_EVENT: cls.op = ev_ok ? OP_EVENT : OP_NONE;
			default:    cls.op = OP_NONE;
		endcase
	end

	assign full      = count_q == 2'd2;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ----- hw/rtl/sap_back.sv -----
// Sequencer: holds the transition table and supervisor state and carries out commands.
// Walks state records through one registered table read port. Depends on sap_pkg.
`timescale 1ns / 1ps

module sap_back #(
	parameter int NUM_EVENTS_P      = sap_pkg::NUM_EVENTS_DEF,
	parameter int NUM_SUPERVISORS_P = sap_pkg::NUM_SUPERVISORS_DEF,
	parameter int TABLE_DEPTH       = sap_pkg::TABLE_DEPTH_DEF,
	parameter int STATE_BITS        = sap_pkg::STATE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  sap_pkg::cmd_t cmd,
	input  logic [31:0]   controllable_mask,
	input  logic [3:0]    active_supervisors,
	output logic          res_empty,
	input  logic          res_pop,
	output logic [31:0]   enabled_mask,
	output logic [7:0]    moved_supervisors
);
	import sap_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int NE  = NUM_EVENTS_P;
	localparam int NS  = NUM_SUPERVISORS_P;
	localparam int SB  = STATE_BITS;
	localparam int SIW = (NS > 1) ? $clog2(NS) : 1;
	localparam int SCW = $clog2(NS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUP,
		ST_WALK_W,
		ST_WALK,
		ST_SCAN_W,
		ST_SCAN,
		ST_HI_W,
		ST_HI,
		ST_LO_W,
		ST_LO,
		ST_EN,
		ST_DONE
	} state_t;

	logic [7:0]    table_mem [TABLE_DEPTH];
	logic [7:0]    rdata_q;
	logic [NE-1:0] memb_q [NS];
	logic [AW-1:0] base_q [NS];
	logic [SB-1:0] init_q [NS];
	logic [SB-1:0] cur_q [NS];

	state_t         state_q;
	logic           apply_q;
	logic [4:0]     ev_q;
	logic [SCW-1:0] s_q;
	logic [SB-1:0]  k_q;
	logic [7:0]     n_q;
	logic [7:0]     j_q;
	logic [AW-1:0]  pos_q;
	logic [7:0]     hi_q;
	logic [NE-1:0]  allowed_q;
	logic [NE-1:0]  en_q;
	logic [NS-1:0]  moved_q;
	logic           out_valid_q;
	logic [31:0]    out_en_q;
	logic [7:0]     out_mv_q;

	logic [SIW-1:0] sidx;
	logic [SIW-1:0] cmd_sidx;
	logic           sup_done;
	logic           owns;
	logic [AW-1:0]  walk_next;
	logic           ev_byte_ok;
	int             act_n;

	always_comb begin
		act_n = (int'(active_supervisors) > NS) ? NS : int'(active_supervisors);
	end

	assign sidx       = SIW'(s_q);
	assign cmd_sidx   = SIW'(16'(cmd.supervisor));
	assign sup_done   = int'(s_q) >= act_n;
	assign owns       = |(memb_q[sidx] & (NE'(1) << ev_q));
	assign walk_next  = AW'(17'(pos_q) + 17'(rdata_q) * 17'd3 + 17'd1);
	assign ev_byte_ok = int'(rdata_q) < NE;
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;

	assign res_empty         = !out_valid_q;
	assign enabled_mask      = out_en_q;
	assign moved_supervisors = out_mv_q;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_WRITE) begin
			table_mem[AW'(cmd.address)] <= cmd.byte_value;
		end
		rdata_q <= table_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			apply_q     <= 1'b0;
			ev_q        <= '0;
			s_q         <= '0;
			k_q         <= '0;
			n_q         <= '0;
			j_q         <= '0;
			pos_q       <= '0;
			hi_q        <= '0;
			allowed_q   <= '0;
			en_q        <= '0;
			moved_q     <= '0;
			out_valid_q <= 1'b0;
			out_en_q    <= '0;
			out_mv_q    <= '0;
			for (int i = 0; i < NS; i++) begin
				memb_q[i] <= '0;
				base_q[i] <= '0;
				init_q[i] <= '0;
				cur_q[i]  <= '0;
			end
		end else begin
			if (res_pop && out_valid_q && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					moved_q <= '0;
					s_q     <= '0;
					ev_q    <= cmd.event_req;
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_MEMB: begin
								memb_q[cmd_sidx] <= NE'(64'(cmd.event_mask));
								state_q <= ST_EN;
							end
							OP_LOAD: begin
								base_q[cmd_sidx] <= AW'(cmd.address);
								init_q[cmd_sidx] <= SB'(cmd.state_value);
								state_q <= ST_EN;
							end
							OP_RESET: begin
								for (int i = 0; i < NS; i++) begin
									cur_q[i] <= init_q[i];
								end
								state_q <= ST_EN;
							end
							OP_EVENT: begin
								apply_q <= 1'b1;
								state_q <= ST_SUP;
							end
							default: state_q <= ST_EN;
						endcase
					end
				end
				ST_SUP: begin
					if (sup_done) begin
						state_q <= apply_q ? ST_EN : ST_DONE;
					end else if (apply_q && !owns) begin
						s_q <= s_q + SCW'(1);
					end else begin
						pos_q     <= base_q[sidx];
						k_q       <= '0;
						allowed_q <= '0;
						state_q   <= ST_WALK_W;
					end
				end
				ST_WALK_W: state_q <= ST_WALK;
				ST_WALK: begin
					if (k_q == cur_q[sidx]) begin
						n_q     <= rdata_q;
						j_q     <= '0;
						pos_q   <= pos_q + AW'(1);
						state_q <= ST_SCAN_W;
					end else begin
						pos_q   <= walk_next;
						k_q     <= k_q + SB'(1);
						state_q <= ST_WALK_W;
					end
				end
				ST_SCAN_W: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (j_q == n_q) begin
						if (!apply_q) begin
							en_q <= en_q & ~(memb_q[sidx] & ~allowed_q);
						end
						s_q     <= s_q + SCW'(1);
						state_q <= ST_SUP;
					end else if (apply_q && rdata_q == 8'(ev_q)) begin
						pos_q   <= pos_q + AW'(1);
						state_q <= ST_HI_W;
					end else begin
						if (!apply_q && ev_byte_ok) begin
							allowed_q <= allowed_q | (NE'(1) << rdata_q);
						end
						pos_q   <= pos_q + AW'(3);
						j_q     <= j_q + 8'd1;
						state_q <= ST_SCAN_W;
					end
				end
				ST_HI_W: state_q <= ST_HI;
				ST_HI: begin
					hi_q    <= rdata_q;
					pos_q   <= pos_q + AW'(1);
					state_q <= ST_LO_W;
				end
				ST_LO_W: state_q <= ST_LO;
				ST_LO: begin
					cur_q[sidx]   <= SB'({hi_q, rdata_q});
					moved_q[sidx] <= 1'b1;
					s_q           <= s_q + SCW'(1);
					state_q       <= ST_SUP;
				end
				ST_EN: begin
					apply_q <= 1'b0;
					s_q     <= '0;
					en_q    <= NE'(64'(controllable_mask));
					state_q <= ST_SUP;
				end
				ST_DONE: begin
					if (!out_valid_q || res_pop) begin
						out_valid_q <= 1'b1;
						out_en_q    <= 32'(64'(en_q));
						out_mv_q    <= 8'(16'(moved_q));
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/supervisor_automata_player.sv -----
// Top level of the supervisor automata player: front end, sequencer and configuration registers.
// Depends on sap_pkg, sap_front and sap_back.
//
// The block runs up to NUM_SUPERVISORS_P automata from a packed byte table and returns
// one result per input item. Items enter a two-entry command queue and are carried out
// one at a time by a sequencer that reads the table through a single port with a
// registered read. A load command stores its base address and initial state before
// the mask pass; every item ends with a pass over all active supervisors that walks to the
// current record, stepping past the records before it, and scans its entries, and
// an applied event walks each owning supervisor's record once more before that pass.
// The cost per item is therefore set by the table contents and the current states.
// The table is not cleared at reset; entries must be written before they are read.
`timescale 1ns / 1ps

module supervisor_automata_player #(
	parameter int NUM_EVENTS_P      = sap_pkg::NUM_EVENTS_DEF,
	parameter int NUM_SUPERVISORS_P = sap_pkg::NUM_SUPERVISORS_DEF,
	parameter int TABLE_DEPTH       = sap_pkg::TABLE_DEPTH_DEF,
	parameter int STATE_BITS        = sap_pkg::STATE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [2:0]                    mode,
	input  logic [sap_pkg::ADDRESS_W-1:0] address,
	input  logic [7:0]                    byte_value,
	input  logic [2:0]                    supervisor,
	input  logic [31:0]                   event_mask,
	input  logic [15:0]                   state_value,
	input  logic [4:0]                    event_req,
	output logic                          empty,
	input  logic                          pop,
	output logic [31:0]                   enabled_mask,
	output logic [7:0]                    moved_supervisors,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import sap_pkg::*;

	logic        cmd_valid;
	logic        cmd_pop;
	cmd_t        cmd;
	logic [31:0] controllable_q;
	logic [3:0]  active_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			controllable_q <= '0;
			active_q       <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_CONTROLLABLE) begin
				controllable_q <= cfg_data;
			end else if (cfg_index == CFG_ACTIVE) begin
				active_q <= cfg_data[3:0];
			end
		end
	end

	sap_front #(
		.NUM_EVENTS_P      (NUM_EVENTS_P),
		.NUM_SUPERVISORS_P (NUM_SUPERVISORS_P)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.address     (address),
		.byte_value  (byte_value),
		.supervisor  (supervisor),
		.event_mask  (event_mask),
		.state_value (state_value),
		.event_req   (event_req),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	sap_back #(
		.NUM_EVENTS_P      (NUM_EVENTS_P),
		.NUM_SUPERVISORS_P (NUM_SUPERVISORS_P),
		.TABLE_DEPTH       (TABLE_DEPTH),
		.STATE_BITS        (STATE_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd_valid          (cmd_valid),
		.cmd_pop            (cmd_pop),
		.cmd                (cmd),
		.controllable_mask  (controllable_q),
		.active_supervisors (active_q),
		.res_empty          (empty),
		.res_pop            (pop),
		.enabled_mask       (enabled_mask),
		.moved_supervisors  (moved_supervisors)
	);

endmodule

// ----- hw/rtl/sap_checker.sv -----
// Port-level checks for the supervisor automata player, bound to the top level.
// Depends on supervisor_automata_player.
`timescale 1ns / 1ps

module sap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] enabled_mask,
	input logic [7:0]  moved_supervisors
);

	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("Result visible during reset.");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("Queue became full without a transfer in.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(enabled_mask) && $stable(moved_supervisors)))
		else $error("Waiting result changed before its transfer.");

endmodule

bind supervisor_automata_player sap_checker u_sap_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.push              (push),
	.full              (full),
	.empty             (empty),
	.pop               (pop),
	.enabled_mask      (enabled_mask),
	.moved_supervisors (moved_supervisors)
);
